// ===== hw/rtl/yaz0_pkg.sv =====
// shared types and constants for the yaz0 lz decompressor
// used by yaz0_hist_mem, yaz0_out_stage and yaz0_lz_decompressor_top
package yaz0_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int OUT_BYTES = 8;
    localparam int DEF_LANES = 8;
    localparam logic [31:0] DEF_MAX_OUT_BYTES = 32'd268435456;
    localparam int M_TDATA_W = 72;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_REF = 2'd3;

    localparam logic [4:0] HDR_BYTES = 5'd16;
    localparam logic [8:0] SHORT_LEN_BIAS = 9'h002;
    localparam logic [8:0] LONG_LEN_BIAS = 9'h012;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        case (pos)
            2'd0: m = 8'h59;
            2'd1: m = 8'h61;
            2'd2: m = 8'h7A;
            default: m = 8'h30;
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic [OUT_BYTES-1:0][7:0] bytes;
        logic [3:0]                count;
        logic                      last;
        logic [1:0]                status;
        logic                      done;
    } beat_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_LAST = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/yaz0_hist_mem.sv =====
// 4096 x 8 history window, one write port and one registered read port
// depends on yaz0_pkg
module yaz0_hist_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [yaz0_pkg::HIST_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [yaz0_pkg::HIST_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import yaz0_pkg::*;

    logic [7:0] mem [HIST_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/yaz0_out_stage.sv =====
// output register for result beats, parts the decoder from the m_ side
// depends on yaz0_pkg
module yaz0_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  yaz0_pkg::beat_t                   beat,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_byte0..out_byte7, byte_count, status, done_res, zero pad
    output logic [yaz0_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import yaz0_pkg::*;

    logic  valid_reg;
    beat_t beat_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && push) begin
            beat_reg <= beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = beat_reg.last;
    assign m_tdata  = {1'b0, beat_reg.done, beat_reg.status, beat_reg.count, beat_reg.bytes};

endmodule

// ===== hw/rtl/yaz0_lz_decompressor_top.sv =====
// yaz0 decompressor top: header/token decoder, copy sequencer and lane packing
// depends on yaz0_pkg, yaz0_hist_mem, yaz0_out_stage
// an accepted byte goes to S_LAST, passing S_RD and S_WR for each byte of a match it starts;
// S_LAST pushes the beat when the output stage is free; s_tready is low outside S_IDLE;
// each copied byte is read from history in S_RD, then written back in S_WR (one port pair)
// reset: aresetn clears stream state except src_reg, pack_reg; history is never cleared
module yaz0_lz_decompressor_top #(
    parameter logic [31:0] MAX_OUT_BYTES = yaz0_pkg::DEF_MAX_OUT_BYTES,
    parameter int          LANES         = yaz0_pkg::DEF_LANES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // data_byte
    input  logic                           s_tuser,  // new_stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte0..out_byte7, byte_count, status, done_res
    output logic [yaz0_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import yaz0_pkg::*;

    localparam logic [3:0] LANES_CNT = 4'(LANES);
    localparam int         LANE_AW   = (LANES > 1) ? $clog2(LANES) : 1;

    state_t            state_reg, state_next;
    logic [4:0]        hdr_reg, hdr_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       prod_reg, prod_next;
    logic [7:0]        grp_reg, grp_next;
    logic [3:0]        bits_reg, bits_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        tok1_reg, tok1_next;
    logic [7:0]        tok2_reg, tok2_next;
    logic [1:0]        err_reg, err_next;
    logic              fin_reg, fin_next;
    logic [HIST_AW-1:0] wptr_reg, wptr_next;
    logic [HIST_AW-1:0] src_reg, src_next;
    logic [8:0]        left_reg, left_next;
    logic [7:0]        pack_reg [LANES];
    logic [7:0]        pack_next [LANES];
    logic [3:0]        cnt_reg, cnt_next;

    logic              mem_we, mem_re;
    logic [HIST_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              out_free, push;
    beat_t             beat;
    logic              beat_last;
    logic [OUT_BYTES-1:0][7:0] lane_bytes;

    yaz0_hist_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (src_reg),
        .rd_data (mem_rdata)
    );

    yaz0_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .beat     (beat),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        logic [8:0]  len;
        logic        do_copy;
        logic [12:0] ref_dist;
        logic [31:0] rem;
        logic [7:0]  b;
        state_next = state_reg;
        hdr_next   = hdr_reg;
        size_next  = size_reg;
        prod_next  = prod_reg;
        grp_next   = grp_reg;
        bits_next  = bits_reg;
        phase_next = phase_reg;
        tok1_next  = tok1_reg;
        tok2_next  = tok2_reg;
        err_next   = err_reg;
        fin_next   = fin_reg;
        wptr_next  = wptr_reg;
        src_next   = src_reg;
        left_next  = left_reg;
        pack_next  = pack_reg;
        cnt_next   = cnt_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = wptr_reg;
        mem_wdata  = mem_rdata;
        push       = 1'b0;
        beat_last  = 1'b0;
        len        = '0;
        do_copy    = 1'b0;
        ref_dist   = '0;
        rem        = '0;
        b          = s_tdata;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cnt_next   = '0;
                    state_next = S_LAST;
                    if (s_tuser) begin
                        hdr_next = '0; size_next = '0; prod_next = '0;
                        grp_next = '0; bits_next = '0; phase_next = '0;
                        tok1_next = '0; tok2_next = '0; err_next = ST_OK;
                        fin_next = 1'b0;
                    end
                    if (err_next == ST_OK && !fin_next) begin
                        if (hdr_next < HDR_BYTES) begin
                            if (hdr_next < 5'd4) begin
                                if (b != magic_byte(hdr_next[1:0])) begin
                                    err_next = ST_BAD_MAGIC;
                                end
                            end else if (hdr_next < 5'd8) begin
                                size_next = {size_next[23:0], b};
                                if (hdr_next == 5'd7 && size_next > MAX_OUT_BYTES) begin
                                    err_next = ST_TOO_LARGE;
                                end
                            end
                            hdr_next = hdr_next + 5'd1;
                            if (hdr_next == HDR_BYTES && err_next == ST_OK && size_next == '0) begin
                                fin_next = 1'b1;
                            end
                        end else if (bits_next == '0) begin
                            grp_next  = b;
                            bits_next = 4'd8;
                        end else if (phase_next == 2'd0 && grp_next[7]) begin
                            // literal
                            mem_we       = 1'b1;
                            mem_waddr    = wptr_next;
                            mem_wdata    = b;
                            wptr_next    = wptr_next + HIST_AW'(1);
                            prod_next    = prod_next + 32'd1;
                            fin_next     = (prod_next == size_next);
                            pack_next[0] = b;
                            cnt_next     = 4'd1;
                            grp_next     = {grp_next[6:0], 1'b0};
                            bits_next    = bits_next - 4'd1;
                        end else if (phase_next == 2'd0) begin
                            tok1_next  = b;
                            phase_next = 2'd1;
                        end else if (phase_next == 2'd1) begin
                            tok2_next = b;
                            if (tok1_next[7:4] != 4'd0) begin
                                do_copy = 1'b1;
                                len     = {5'd0, tok1_next[7:4]} + SHORT_LEN_BIAS;
                            end else begin
                                phase_next = 2'd2;
                            end
                        end else begin
                            do_copy = 1'b1;
                            len     = {1'b0, b} + LONG_LEN_BIAS;
                        end

                        if (do_copy) begin
                            phase_next = 2'd0;
                            grp_next   = {grp_next[6:0], 1'b0};
                            bits_next  = bits_next - 4'd1;
                            ref_dist   = {1'b0, tok1_next[3:0], tok2_next} + 13'd1;
                            if ({19'd0, ref_dist} > prod_next) begin
                                err_next = ST_BAD_REF;
                            end else begin
                                rem = size_next - prod_next;
                                if (rem < {23'd0, len}) begin
                                    left_next = rem[8:0];
                                end else begin
                                    left_next = len;
                                end
                                fin_next   = ({23'd0, left_next} == rem);
                                prod_next  = prod_next + {23'd0, left_next};
                                src_next   = wptr_next - ref_dist[HIST_AW-1:0];
                                state_next = S_RD;
                            end
                        end
                    end
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                if (cnt_reg == LANES_CNT) begin
                    // lanes full: ship them before taking this byte
                    if (out_free) begin
                        push         = 1'b1;
                        pack_next[0] = mem_rdata;
                        cnt_next     = 4'd1;
                    end
                end else begin
                    pack_next[cnt_reg[LANE_AW-1:0]] = mem_rdata;
                    cnt_next = cnt_reg + 4'd1;
                end
                if (cnt_reg != LANES_CNT || out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = wptr_reg;
                    mem_wdata  = mem_rdata;
                    wptr_next  = wptr_reg + HIST_AW'(1);
                    src_next   = src_reg + HIST_AW'(1);
                    left_next  = left_reg - 9'd1;
                    state_next = (left_reg == 9'd1) ? S_LAST : S_RD;
                end
            end
            S_LAST: begin
                if (out_free) begin
                    push       = 1'b1;
                    beat_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        beat.bytes  = lane_bytes;
        beat.count  = cnt_reg;
        beat.last   = beat_last;
        beat.status = err_reg;
        beat.done   = fin_reg;
    end

    for (genvar j = 0; j < OUT_BYTES; j++) begin : g_lane
        if (j < LANES) begin : g_used
            assign lane_bytes[j] = (4'(j) < cnt_reg) ? pack_reg[j] : 8'd0;
        end else begin : g_unused
            assign lane_bytes[j] = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hdr_reg   <= '0;
            size_reg  <= '0;
            prod_reg  <= '0;
            grp_reg   <= '0;
            bits_reg  <= '0;
            phase_reg <= '0;
            tok1_reg  <= '0;
            tok2_reg  <= '0;
            err_reg   <= ST_OK;
            fin_reg   <= 1'b0;
            wptr_reg  <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            hdr_reg   <= hdr_next;
            size_reg  <= size_next;
            prod_reg  <= prod_next;
            grp_reg   <= grp_next;
            bits_reg  <= bits_next;
            phase_reg <= phase_next;
            tok1_reg  <= tok1_next;
            tok2_reg  <= tok2_next;
            err_reg   <= err_next;
            fin_reg   <= fin_next;
            wptr_reg  <= wptr_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg  <= src_next;
        pack_reg <= pack_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LANES_CNT)
        else $error("lane count beyond lanes");

    a_rd_then_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD |=> state_reg == S_WR)
        else $error("history read not followed by write back");

    a_copy_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_WR) |-> left_reg != 9'd0)
        else $error("copy running with nothing left");

    a_done_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fin_reg && err_reg != ST_OK))
        else $error("done and error flagged together");

endmodule
